// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file rgbp_checker.sv
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_CLK_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/rgbp_pkg.sv =====
// shared types, command codes and the gamma table for the rgb led pwm block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rgbp_pkg;

    // command codes carried in the input tuser
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_RGB  = 2'd1;
    localparam logic [1:0] FUNC_HUE  = 2'd2;

    // duty value after reset
    localparam logic [7:0] DUTY_RESET = 8'd10;

    // upper bounds of the hue segments
    localparam logic [7:0] HUE_SEG0 = 8'd42;
    localparam logic [7:0] HUE_SEG1 = 8'd85;
    localparam logic [7:0] HUE_SEG2 = 8'd127;
    localparam logic [7:0] HUE_SEG3 = 8'd170;
    localparam logic [7:0] HUE_SEG4 = 8'd212;
    localparam logic [7:0] HUE_MAX  = 8'd255;

    // one input item
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] hue;
    } t_item;

    // one color as three bytes
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    // gamma table indexed by the top five bits of a color byte
    function automatic logic [7:0] gamma_lut(input logic [4:0] idx);
        logic [7:0] v;
        case (idx)
            5'd0:  v = 8'd0;
            5'd1:  v = 8'd1;
            5'd2:  v = 8'd2;
            5'd3:  v = 8'd3;
            5'd4:  v = 8'd4;
            5'd5:  v = 8'd6;
            5'd6:  v = 8'd7;
            5'd7:  v = 8'd9;
            5'd8:  v = 8'd10;
            5'd9:  v = 8'd12;
            5'd10: v = 8'd13;
            5'd11: v = 8'd15;
            5'd12: v = 8'd17;
            5'd13: v = 8'd19;
            5'd14: v = 8'd21;
            5'd15: v = 8'd23;
            5'd16: v = 8'd25;
            5'd17: v = 8'd27;
            5'd18: v = 8'd30;
            5'd19: v = 8'd33;
            5'd20: v = 8'd36;
            5'd21: v = 8'd39;
            5'd22: v = 8'd42;
            5'd23: v = 8'd46;
            5'd24: v = 8'd51;
            5'd25: v = 8'd56;
            5'd26: v = 8'd61;
            5'd27: v = 8'd68;
            5'd28: v = 8'd76;
            5'd29: v = 8'd87;
            5'd30: v = 8'd102;
            5'd31: v = 8'd128;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/rgbp_hue.sv =====
// hue to rgb conversion over six linear segments, purely combinational
// depends on rgbp_pkg
`timescale 1ns / 1ps
`default_nettype none

module rgbp_hue
    import rgbp_pkg::*;
(
    input  wire logic [7:0] i_hue,
    output t_rgb            o_rgb
);

    // multiply a small value by six; the segments keep the product below 256
    function automatic logic [7:0] times6(input logic [7:0] x);
        return 8'((x << 2) + (x << 1));
    endfunction

    // pick the segment and form the ramps
    always_comb begin
        if (i_hue <= HUE_SEG0) begin
            o_rgb = '{r: 8'hFF, g: times6(i_hue), b: 8'h00};
        end else if (i_hue <= HUE_SEG1) begin
            o_rgb = '{r: times6(HUE_SEG1 - i_hue), g: 8'hFF, b: 8'h00};
        end else if (i_hue <= HUE_SEG2) begin
            o_rgb = '{r: 8'h00, g: 8'hFF, b: times6(i_hue - HUE_SEG1)};
        end else if (i_hue <= HUE_SEG3) begin
            o_rgb = '{r: 8'h00, g: times6(HUE_SEG3 - i_hue), b: 8'hFF};
        end else if (i_hue <= HUE_SEG4) begin
            o_rgb = '{r: times6(i_hue - HUE_SEG3), g: 8'h00, b: 8'hFF};
        end else begin
            o_rgb = '{r: 8'hFF, g: 8'h00, b: times6(HUE_MAX - i_hue)};
        end
    end

endmodule

`default_nettype wire

// ===== sv/rgbp_state.sv =====
// pwm counter, duty registers and pin level registers, updated once per item
// depends on rgbp_pkg and rgbp_hue
`timescale 1ns / 1ps
`default_nettype none

module rgbp_state
    import rgbp_pkg::*;
#(
    parameter int PWM_PERIOD = 128
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire t_item      i_item,
    output logic      [2:0] o_levels_next
);

    localparam int CW    = $clog2(PWM_PERIOD);
    localparam int SW    = CW + 1;
    localparam int OFF_G = PWM_PERIOD / 3;
    localparam int OFF_B = (PWM_PERIOD / 3) * 2;
    localparam logic [SW-1:0] PERIOD_S = SW'(PWM_PERIOD);
    localparam logic [CW-1:0] CNT_LAST = CW'(PWM_PERIOD - 1);

    logic [CW-1:0] r_cnt,     n_cnt;
    logic [7:0]    r_duty_r,  n_duty_r;
    logic [7:0]    r_duty_g,  n_duty_g;
    logic [7:0]    r_duty_b,  n_duty_b;
    logic [2:0]    r_pending, n_pending;
    logic [2:0]    r_driven,  n_driven;

    t_rgb          hue_rgb;
    logic [CW-1:0] cnt_inc;
    logic [SW-1:0] sum_g, sum_b;
    logic [CW-1:0] ph_g, ph_b;

    rgbp_hue u_hue (
        .i_hue (i_item.hue),
        .o_rgb (hue_rgb)
    );

    // counter advance, wrapped to zero at the end, and phase-shifted counts, each wrapped by one subtract
    always_comb begin
        cnt_inc = (r_cnt == CNT_LAST) ? '0 : r_cnt + 1'b1;
        sum_g   = {1'b0, cnt_inc} + SW'(OFF_G);
        sum_b   = {1'b0, cnt_inc} + SW'(OFF_B);
        ph_g    = (sum_g >= PERIOD_S) ? CW'(sum_g - PERIOD_S) : CW'(sum_g);
        ph_b    = (sum_b >= PERIOD_S) ? CW'(sum_b - PERIOD_S) : CW'(sum_b);
    end

    // next state per command
    always_comb begin
        n_cnt     = r_cnt;
        n_duty_r  = r_duty_r;
        n_duty_g  = r_duty_g;
        n_duty_b  = r_duty_b;
        n_pending = r_pending;
        n_driven  = r_driven;
        case (i_item.func)
            FUNC_TICK: begin
                n_driven     = r_pending;
                n_cnt        = cnt_inc;
                n_pending[0] = 9'(cnt_inc) < {1'b0, r_duty_r};
                n_pending[1] = 9'(ph_g) < {1'b0, r_duty_g};
                n_pending[2] = 9'(ph_b) < {1'b0, r_duty_b};
            end
            FUNC_RGB: begin
                n_duty_r = gamma_lut(i_item.red[7:3]);
                n_duty_g = gamma_lut(i_item.green[7:3]);
                n_duty_b = gamma_lut(i_item.blue[7:3]);
            end
            FUNC_HUE: begin
                n_duty_r = gamma_lut(hue_rgb.r[7:3]);
                n_duty_g = gamma_lut(hue_rgb.g[7:3]);
                n_duty_b = gamma_lut(hue_rgb.b[7:3]);
            end
            default: begin
            end
        endcase
    end

    assign o_levels_next = n_driven;

    // state registers, written when an item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_duty_r  <= DUTY_RESET;
            r_duty_g  <= DUTY_RESET;
            r_duty_b  <= DUTY_RESET;
            r_pending <= '0;
            r_driven  <= '0;
        end else if (i_step) begin
            r_cnt     <= n_cnt;
            r_duty_r  <= n_duty_r;
            r_duty_g  <= n_duty_g;
            r_duty_b  <= n_duty_b;
            r_pending <= n_pending;
            r_driven  <= n_driven;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rgb_led_pwm_with_hue_input_core.sv =====
// top level of the three-channel led pwm generator with gamma and hue input
// depends on rgbp_pkg, rgbp_state and rgbp_hue
//
// usage:
//   input stream: s_axis_tuser carries the command (0 tick, 1 set rgb,
//   2 set hue, 3 no operation); s_axis_tdata carries the red, green, blue
//   and hue bytes. every accepted item yields exactly one output item whose
//   tdata holds the pin levels being driven after that item.
//   a tick drives the levels latched on the previous tick, advances the
//   counter modulo PWM_PERIOD and latches new levels from the duties.
//   set rgb and set hue only load the duties through the gamma table.
// pipeline and throughput:
//   an accepted item passes the input register, then the result register;
//   one item per cycle sustained while m_axis_tready stays high, set by the
//   single combinational step between the two registers.
// reset: synchronous, active low; counter and levels clear, duties load 10,
//   both stages empty.
// stall: while the result waits, one further item is taken into the input
//   register; after that s_axis_tready drops until m_axis_tready returns.
`timescale 1ns / 1ps
`default_nettype none

module rgb_led_pwm_with_hue_input_core
    import rgbp_pkg::*;
#(
    parameter int PWM_PERIOD = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // red, green, blue, hue
    input  wire logic [1:0]  s_axis_tuser,  // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [7:0]  m_axis_tdata   // red_on, green_on, blue_on, zero pad
);

    logic       r_in_valid;
    t_item      r_in;
    logic       r_out_valid;
    logic [2:0] r_out_levels;
    logic       advance;
    logic       step;
    logic [2:0] levels_next;

    // pipeline moves when the result register is free or being emptied
    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= '{func:  s_axis_tuser,
                      red:   s_axis_tdata[7:0],
                      green: s_axis_tdata[15:8],
                      blue:  s_axis_tdata[23:16],
                      hue:   s_axis_tdata[31:24]};
        end
    end

    rgbp_state #(
        .PWM_PERIOD (PWM_PERIOD)
    ) u_state (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_item        (r_in),
        .o_levels_next (levels_next)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_levels <= levels_next;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_levels};

endmodule

`default_nettype wire

// ===== sv/rgbp_checker.sv =====
// port-level checks for the rgb led pwm block, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rgbp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata
);

    // result offered but not taken
    logic stalled;
    assign stalled = m_axis_tvalid && !m_axis_tready;

    // reset empties the result stage
    `ASSERT_CLK_NR(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "valid after reset")

    // with no result pending the block always takes an item
    `ASSERT_CLK(a_rdy_empty, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready, "not ready")

    // a stalled result stays valid
    `ASSERT_CLK(a_valid_hold, i_clk, i_rst_n, stalled |=> m_axis_tvalid, "valid dropped")

    // a stalled result keeps its levels
    `ASSERT_CLK(a_data_hold, i_clk, i_rst_n, stalled |=> $stable(m_axis_tdata), "data changed")

endmodule

bind rgb_led_pwm_with_hue_input_core rgbp_checker u_rgbp_checker (.*);

`default_nettype wire

// ===== test/rgb_led_pwm_with_hue_input_core_tb.sv =====
// testbench for the three-channel led pwm generator with gamma and hue input
// depends on rgbp_pkg and rgb_led_pwm_with_hue_input_core; predicts each pin item
// from its own pwm model and checks every output item in order
`timescale 1ns / 1ps

module rgb_led_pwm_with_hue_input_core_tb;
    import rgbp_pkg::*;

    localparam int PWM_PERIOD   = 128;
    localparam int CLK_HALF_NS  = 6;
    localparam int RESET_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 650;

    // unused command code, the block treats it as no operation
    localparam logic [1:0] FUNC_NOP = 2'd3;

    // gamma curve, entry 0 in the lowest byte
    localparam logic [255:0] GAMMA_CURVE = {
        8'd128, 8'd102, 8'd87, 8'd76, 8'd68, 8'd61, 8'd56, 8'd51,
        8'd46,  8'd42,  8'd39, 8'd36, 8'd33, 8'd30, 8'd27, 8'd25,
        8'd23,  8'd21,  8'd19, 8'd17, 8'd15, 8'd13, 8'd12, 8'd10,
        8'd9,   8'd7,   8'd6,  8'd4,  8'd3,  8'd2,  8'd1,  8'd0
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // red, green, blue, hue
    logic [1:0]  s_axis_tuser;   // func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // red_on, green_on, blue_on, zero pad

    // pwm model state
    int         pwm_count;
    logic [7:0] duty_r;
    logic [7:0] duty_g;
    logic [7:0] duty_b;
    logic [2:0] latched_levels;
    logic [2:0] pin_levels;

    // pin levels still to come out of the block, oldest first
    logic [2:0] expected_levels[$];

    int src_idle_pct;
    int sink_idle_pct;
    int error_count;
    int stall_cycles;

    rgb_led_pwm_with_hue_input_core #(
        .PWM_PERIOD(PWM_PERIOD)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #CLK_HALF_NS;
        i_clk = 1'b1;
        #CLK_HALF_NS;
    end

    function automatic logic [7:0] gamma_of(input logic [7:0] level);
        return GAMMA_CURVE[level[7:3] * 8 +: 8];
    endfunction

    // full saturation hue wheel, six linear segments
    function automatic t_rgb hue_to_rgb(input logic [7:0] h);
        t_rgb c;
        int hv;
        int r;
        int g;
        int b;
        hv = h;
        if (hv <= HUE_SEG0) begin
            r = 255; g = 6 * hv; b = 0;
        end else if (hv <= HUE_SEG1) begin
            r = 6 * (HUE_SEG1 - hv); g = 255; b = 0;
        end else if (hv <= HUE_SEG2) begin
            r = 0; g = 255; b = 6 * (hv - HUE_SEG1);
        end else if (hv <= HUE_SEG3) begin
            r = 0; g = 6 * (HUE_SEG3 - hv); b = 255;
        end else if (hv <= HUE_SEG4) begin
            r = 6 * (hv - HUE_SEG3); g = 0; b = 255;
        end else begin
            r = 255; g = 0; b = 6 * (HUE_MAX - hv);
        end
        c.r = r[7:0];
        c.g = g[7:0];
        c.b = b[7:0];
        return c;
    endfunction

    function automatic void load_duties(input t_rgb c);
        duty_r = gamma_of(c.r);
        duty_g = gamma_of(c.g);
        duty_b = gamma_of(c.b);
    endfunction

    // advance the pwm model by one accepted item and queue the pin levels
    function automatic void predict_levels(input t_item it);
        t_rgb c;
        case (it.func)
            FUNC_TICK: begin
                pin_levels = latched_levels;
                pwm_count = (pwm_count + 1) % PWM_PERIOD;
                latched_levels[0] = pwm_count < int'(duty_r);
                latched_levels[1] = ((pwm_count + PWM_PERIOD / 3) % PWM_PERIOD)
                                    < int'(duty_g);
                latched_levels[2] = ((pwm_count + 2 * (PWM_PERIOD / 3)) % PWM_PERIOD)
                                    < int'(duty_b);
            end
            FUNC_RGB: begin
                c.r = it.red;
                c.g = it.green;
                c.b = it.blue;
                load_duties(c);
            end
            FUNC_HUE: begin
                load_duties(hue_to_rgb(it.hue));
            end
            default: begin
            end
        endcase
        expected_levels.push_back(pin_levels);
    endfunction

    function automatic t_item make_item(input logic [1:0] f, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b,
                                        input logic [7:0] h);
        t_item it;
        it.func  = f;
        it.red   = r;
        it.green = g;
        it.blue  = b;
        it.hue   = h;
        return it;
    endfunction

    // byte biased toward the ends of its range
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_item random_item(input logic [1:0] f);
        return make_item(f, pick_byte(), pick_byte(), pick_byte(), pick_byte());
    endfunction

    // send one item, with random gaps before it
    task automatic send_item(input t_item it);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.hue, it.blue, it.green, it.red};
        s_axis_tuser  <= it.func;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_levels(it);
    endtask

    // hold the sender off until every queued item has come back
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_levels.size() != 0);
    endtask

    task automatic send_ticks(input int n);
        for (int k = 0; k < n; k++) send_item(random_item(FUNC_TICK));
    endtask

    // ticks on the reset duties, plus the unused command
    task automatic test_reset_duties();
        send_ticks(3);
        send_item(random_item(FUNC_NOP));
        send_ticks(2);
    endtask

    // full, zero and mixed colors through the gamma table
    task automatic test_rgb_extremes();
        send_item(make_item(FUNC_RGB, 8'd255, 8'd255, 8'd255, 8'd0));
        send_ticks(2);
        send_item(make_item(FUNC_RGB, 8'd0, 8'd0, 8'd0, 8'd255));
        send_ticks(2);
        send_item(make_item(FUNC_RGB, 8'h07, 8'hf8, 8'h80, 8'h55));
        send_ticks(1);
    endtask

    // both ends of every hue segment
    task automatic test_hue_segments();
        logic [7:0] hues[12];
        hues = '{8'd0, 8'd42, 8'd43, 8'd85, 8'd86, 8'd127,
                 8'd128, 8'd170, 8'd171, 8'd212, 8'd213, 8'd255};
        foreach (hues[i]) send_item(make_item(FUNC_HUE, pick_byte(), pick_byte(),
                                              pick_byte(), hues[i]));
        send_ticks(1);
    endtask

    // color changes followed by tick runs with occasional no-op items, some long enough to wrap the counter
    task automatic test_random_runs(input int n_items);
        int sent;
        int run_len;
        sent = 0;
        while (sent < n_items) begin
            send_item(random_item($urandom_range(0, 1) ? FUNC_RGB : FUNC_HUE));
            sent++;
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(129, 300)
                                                 : $urandom_range(0, 40);
            for (int k = 0; k < run_len && sent < n_items; k++) begin
                if ($urandom_range(0, 29) == 0) begin
                    send_item(random_item(FUNC_NOP));
                end else begin
                    send_item(random_item(FUNC_TICK));
                end
                sent++;
            end
            if ($urandom_range(0, 19) == 0) wait_drain();
        end
    endtask

    // output side: random stalls and in-order comparison
    always @(posedge i_clk) begin
        logic [2:0] want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_levels.size() == 0) begin
                    if (error_count < MAX_REPORTS)
                        $display("unexpected output item: tdata=%h", m_axis_tdata);
                    error_count++;
                end else begin
                    want = expected_levels.pop_front();
                    if (m_axis_tdata[0] !== want[0] || m_axis_tdata[1] !== want[1] ||
                        m_axis_tdata[2] !== want[2] || m_axis_tdata[7:3] !== 5'd0) begin
                        if (error_count < MAX_REPORTS)
                            $display("pin mismatch: exp bgr=%b pad=0, got bgr=%b pad=%h",
                                     want, m_axis_tdata[2:0], m_axis_tdata[7:3]);
                        error_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("rgb_led_pwm_with_hue_input_core_tb: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FUNC_TICK;
        m_axis_tready <= 1'b0;
        stall_cycles  = 0;
        error_count   = 0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        pwm_count      = 0;
        duty_r         = DUTY_RESET;
        duty_g         = DUTY_RESET;
        duty_b         = DUTY_RESET;
        latched_levels = 3'b000;
        pin_levels     = 3'b000;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_duties();
        test_rgb_extremes();
        test_hue_segments();
        wait_drain();

        src_idle_pct  = 24;
        sink_idle_pct = 59;
        test_random_runs(PHASE_ITEMS);
        src_idle_pct  = 59;
        sink_idle_pct = 24;
        test_random_runs(PHASE_ITEMS);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_runs(PHASE_ITEMS);

        // let the pipeline empty, then watch for stray items
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        error_count += expected_levels.size();

        if (error_count == 0) begin
            $display("rgb_led_pwm_with_hue_input_core_tb: PASS");
        end else begin
            $display("rgb_led_pwm_with_hue_input_core_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/rgbp_pkg.sv
sv/rgbp_hue.sv
sv/rgbp_state.sv
sv/rgb_led_pwm_with_hue_input_core.sv
sv/rgbp_checker.sv
test/rgb_led_pwm_with_hue_input_core_tb.sv
